// ===== rtl/core/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared constants and types for the serial receive deframer.
// ----------------------------------------------------------------------------
package csd_pkg;

  localparam int BufferBytesDefault = 32;

  localparam logic [7:0] EscByte      = 8'hFF;
  localparam logic [7:0] EndByte      = 8'h00;
  localparam logic [7:0] CmdByte0     = 8'h08;
  localparam logic [7:0] CmdVersion   = 8'h92;
  localparam logic [7:0] CmdKey       = 8'hE0;
  localparam logic [7:0] ProtoMask    = 8'hF8;
  localparam logic [7:0] ProtoBus0    = 8'h50;
  localparam logic [7:0] ProtoBus1    = 8'h58;
  localparam logic [7:0] ExtIdMask    = 8'h1F;
  localparam logic [7:0] StdIdMask    = 8'h07;
  localparam logic [7:0] ExtFlagMask  = 8'h80;

  localparam int KeyMsgBytes  = 18;
  localparam int MaxDataBytes = 8;

  localparam logic [1:0] KindFrame   = 2'd0;
  localparam logic [1:0] KindVersion = 2'd1;
  localparam logic [1:0] KindKey     = 2'd2;

  typedef struct packed {
    logic        emit;
    logic [1:0]  kind;
    logic        bus_index;
    logic        extended_id;
    logic [28:0] identifier;
    logic [3:0]  data_length;
    logic [2:0]  data_pos;
    logic        has_timestamp;
    logic [3:0]  reads;
  } close_dec_t;

endpackage

// ===== rtl/core/csd_close_eval.sv =====
// ----------------------------------------------------------------------------
// csd_close_eval
// Decides at a message close whether it is a command, a valid frame or
// nothing, from the byte count, the overflow and suspend flags and the first five captured bytes.
// ----------------------------------------------------------------------------
module csd_close_eval #(
  parameter int BUFFER_BYTES = csd_pkg::BufferBytesDefault
) (
  input  logic [$clog2(BUFFER_BYTES+1)-1:0] byte_count,
  input  logic                              overflowed,
  input  logic                              capture_suspended,
  input  logic [4:0][7:0]                   head,
  output csd_pkg::close_dec_t               dec
);
  import csd_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic          cmd_ver;
  logic          cmd_key;
  logic          proto_ok;
  logic          ts;
  logic          ext;
  logic [2:0]    pos;
  logic [3:0]    need;
  logic [CW-1:0] rest;
  logic          len_ok;
  logic          frame_ok;

  always_comb begin
    cmd_ver  = (byte_count == CW'(2)) && (head[0] == CmdByte0) && (head[1] == CmdVersion);
    cmd_key  = (byte_count == CW'(KeyMsgBytes)) && (head[0] == CmdByte0) &&
               (head[1] == CmdKey);
    proto_ok = ((head[0] & ProtoMask) == ProtoBus0) || ((head[0] & ProtoMask) == ProtoBus1);
    ts       = head[0][0];
    ext      = (head[1] & ExtFlagMask) != 8'h00;
    pos      = ext ? 3'd5 : 3'd3;
    need     = {1'b0, pos} + (ts ? 4'd3 : 4'd0);
    rest     = byte_count - CW'(need);
    len_ok   = (byte_count >= CW'(need)) && (rest <= CW'(MaxDataBytes));
    frame_ok = proto_ok && !head[0][1] && len_ok && !capture_suspended;

    dec = '0;
    if (!overflowed) begin
      if (cmd_ver) begin
        dec.emit = 1'b1;
        dec.kind = KindVersion;
      end else if (cmd_key) begin
        dec.emit = 1'b1;
        dec.kind = KindKey;
      end else if (frame_ok) begin
        dec.emit          = 1'b1;
        dec.kind          = KindFrame;
        dec.bus_index     = (head[0] & ProtoMask) == ProtoBus1;
        dec.extended_id   = ext;
        dec.identifier    = ext ? {head[1][4:0] & ExtIdMask[4:0], head[2], head[3], head[4]}
                                : {18'd0, head[1][2:0] & StdIdMask[2:0], head[2]};
        dec.data_length   = rest[3:0];
        dec.data_pos      = pos;
        dec.has_timestamp = ts;
        dec.reads         = rest[3:0] + (ts ? 4'd2 : 4'd0);
      end
    end
  end

endmodule

// ===== rtl/core/can_serial_rx_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// can_serial_rx_deframer_unit
// Unescapes a serial byte stream into a message buffer and reports CAN
// frames and command requests when a message closes.
//
// Channel   Dir  Signals                 Contents
// s_axis    in   tvalid/tready/tdata[7:0] rx_byte
// m_axis    out  tvalid/tready/tdata/tuser one frame or command report
// cfg       in   cfg_we/cfg_wdata         capture_suspended
//
// An ordinary byte is taken in the idle state. A closing byte passes an
// evaluation state, a read state when R is nonzero, where R is the data
// length plus two for a timestamp, and a finish state that hands over the
// result. The single read port of the buffer makes the reads go one by one.
// Reset clears the control state; the buffer itself is not cleared.
// A stalled output only holds the block at the end of a close.
// ----------------------------------------------------------------------------
module can_serial_rx_deframer_unit #(
  parameter int BUFFER_BYTES = csd_pkg::BufferBytesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] bus_index, [1] extended_id, [30:2] identifier, [34:31] data_length,
  // [98:35] payload, [99] has_timestamp, [115:100] time_stamp, [119:116] zero
  output logic [119:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  input  logic         cfg_we,
  input  logic         cfg_wdata       // [0] capture_suspended
);
  import csd_pkg::*;

  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int AW = $clog2(BUFFER_BYTES);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StEval   = 2'd1;
  localparam logic [1:0] StRead   = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]     state;
  logic           capture_suspended;
  logic           escape_pending;
  logic [CW-1:0]  byte_count;
  logic           overflowed;
  logic [4:0][7:0] head;
  logic [7:0]     pend_byte;
  close_dec_t     dec_now;
  close_dec_t     dec;
  logic [3:0]     rd_idx;
  logic [7:0]     mem [BUFFER_BYTES];
  logic [7:0]     rd_data;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [63:0]    payload;
  logic [15:0]    stamp;

  logic           accept;
  logic           put;
  logic           close;
  logic           finish_go;
  logic [CW-1:0]  rd_addr_wide;
  logic [3:0]     cap_idx;

  logic           out_valid;
  logic [1:0]     out_kind;
  logic           out_bus;
  logic           out_ext;
  logic [28:0]    out_id;
  logic [3:0]     out_len;
  logic [63:0]    out_payload;
  logic           out_has_ts;
  logic [15:0]    out_stamp;

  csd_close_eval #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_eval (
    .byte_count       (byte_count),
    .overflowed       (overflowed),
    .capture_suspended(capture_suspended),
    .head             (head),
    .dec              (dec_now)
  );

  assign s_axis_tready = (state == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign put           = accept && ((!escape_pending && s_axis_tdata != EscByte) ||
                                    (escape_pending && s_axis_tdata == EscByte));
  assign close         = accept && escape_pending && (s_axis_tdata != EscByte);
  assign finish_go     = (state == StFinish) && (!out_valid || m_axis_tready);
  assign cap_idx       = rd_idx - 4'd1;

  always_comb begin
    rd_addr_wide = CW'(dec.data_pos) + CW'(rd_idx) +
                   ((rd_idx >= dec.data_length) ? CW'(1) : CW'(0));
    rd_addr      = rd_addr_wide[AW-1:0];

    wr_en   = 1'b0;
    wr_addr = byte_count[AW-1:0];
    wr_data = s_axis_tdata;
    if (put && byte_count < CW'(BUFFER_BYTES)) begin
      wr_en = 1'b1;
    end else if (finish_go && pend_byte != EndByte) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = pend_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_suspended <= 1'b0;
    end else if (cfg_we) begin
      capture_suspended <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= StIdle;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      overflowed     <= 1'b0;
      rd_idx         <= '0;
    end else begin
      unique case (state)
        StIdle: begin
          if (accept) begin
            escape_pending <= !escape_pending && (s_axis_tdata == EscByte);
            if (put) begin
              if (byte_count < CW'(BUFFER_BYTES)) begin
                byte_count <= byte_count + CW'(1);
              end else begin
                overflowed <= 1'b1;
              end
            end
            if (close) begin
              state <= StEval;
            end
          end
        end
        StEval: begin
          rd_idx <= '0;
          state  <= (dec_now.reads != 4'd0) ? StRead : StFinish;
        end
        StRead: begin
          if (rd_idx < dec.reads) begin
            rd_idx <= rd_idx + 4'd1;
          end else begin
            state <= StFinish;
          end
        end
        StFinish: begin
          if (finish_go) begin
            overflowed <= 1'b0;
            byte_count <= (pend_byte != EndByte) ? CW'(1) : CW'(0);
            state      <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (put && byte_count < CW'(5)) begin
      head[byte_count[2:0]] <= s_axis_tdata;
    end else if (finish_go && pend_byte != EndByte) begin
      head[0] <= pend_byte;
    end
    if (close) begin
      pend_byte <= s_axis_tdata;
    end
    if (state == StEval) begin
      dec     <= dec_now;
      payload <= '0;
      stamp   <= '0;
    end
    if (state == StRead && rd_idx != 4'd0) begin
      if (cap_idx < dec.data_length) begin
        for (int b = 0; b < MaxDataBytes; b++) begin
          if (cap_idx == 4'(b)) begin
            payload[8*b +: 8] <= rd_data;
          end
        end
      end else if (cap_idx == dec.data_length) begin
        stamp[15:8] <= rd_data;
      end else begin
        stamp[7:0] <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go && dec.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go && dec.emit) begin
      out_kind    <= dec.kind;
      out_bus     <= dec.bus_index;
      out_ext     <= dec.extended_id;
      out_id      <= dec.identifier;
      out_len     <= dec.data_length;
      out_payload <= payload;
      out_has_ts  <= dec.has_timestamp;
      out_stamp   <= stamp;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {4'd0, out_stamp, out_has_ts, out_payload, out_len, out_id,
                          out_ext, out_bus};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(BUFFER_BYTES))
    else $error("byte count beyond buffer size");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> byte_count == CW'(BUFFER_BYTES))
    else $error("overflow flagged with room left in buffer");

  a_close_restart: assert property (@(posedge clk) disable iff (rst)
    finish_go |=> (byte_count <= CW'(1)) && !overflowed && !escape_pending)
    else $error("message state not restarted after close");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == StRead) |-> rd_idx <= dec.reads && dec.emit)
    else $error("buffer read index past the planned reads");

endmodule
